// ----- rtl/lmp_pkg.sv -----
`default_nettype none
package lmp_pkg;
  localparam int TblLen = 24;
  localparam int AngW = 26;
  localparam logic signed [AngW-1:0] Deg90 = 26'sd2949120;
  localparam logic signed [AngW-1:0] Deg180 = 26'sd5898240;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic [1:0] REG_KNOWN_ID = 2'd0;
  localparam logic [1:0] REG_LM_X = 2'd1;
  localparam logic [1:0] REG_LM_Y = 2'd2;
  localparam logic [1:0] REG_LM_ANGLE = 2'd3;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        5'd0: r = 26'sd1474560;
        5'd1: r = 26'sd870484;
        5'd2: r = 26'sd459940;
        5'd3: r = 26'sd233473;
        5'd4: r = 26'sd117189;
        5'd5: r = 26'sd58652;
        5'd6: r = 26'sd29333;
        5'd7: r = 26'sd14667;
        5'd8: r = 26'sd7334;
        5'd9: r = 26'sd3667;
        5'd10: r = 26'sd1833;
        5'd11: r = 26'sd917;
        5'd12: r = 26'sd458;
        5'd13: r = 26'sd229;
        5'd14: r = 26'sd115;
        5'd15: r = 26'sd57;
        5'd16: r = 26'sd29;
        5'd17: r = 26'sd14;
        5'd18: r = 26'sd7;
        5'd19: r = 26'sd4;
        5'd20: r = 26'sd2;
        5'd21: r = 26'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/lmp_cordic_stage.sv -----
`default_nettype none
// One registered CORDIC micro-rotation. rotate mode steers on z, vectoring on y.
module lmp_cordic_stage #(
  parameter int W = 36,
  parameter int Shift = 0,
  parameter bit Vectoring = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic signed [lmp_pkg::AngW-1:0] z_in,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic signed [lmp_pkg::AngW-1:0] z_out
);
  import lmp_pkg::*;
  logic dir;
  logic signed [AngW-1:0] step;
  assign step = atan_entry(5'(Shift));
  assign dir = Vectoring ? ~y_in[W-1] : ~z_in[AngW-1];
  always_ff @(posedge clk) begin
    if (Vectoring ? dir : dir) begin
      if (Vectoring) begin
        x_out <= x_in + (y_in >>> Shift);
        y_out <= y_in - (x_in >>> Shift);
        z_out <= z_in + step;
      end else begin
        x_out <= x_in - (y_in >>> Shift);
        y_out <= y_in + (x_in >>> Shift);
        z_out <= z_in - step;
      end
    end else begin
      if (Vectoring) begin
        x_out <= x_in - (y_in >>> Shift);
        y_out <= y_in + (x_in >>> Shift);
        z_out <= z_in - step;
      end else begin
        x_out <= x_in + (y_in >>> Shift);
        y_out <= y_in - (x_in >>> Shift);
        z_out <= z_in + step;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/landmark_pose_2d.sv -----
`default_nettype none
// landmark_pose_2d: robot world pose from one landmark sighting.
// CORDIC_STAGES is capped at 24, for each of the two CORDIC chains.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// Reset: rst (sync, active high) clears the valid chain and loads the
// register defaults (known_id 0, landmark 2.0 ft, 0, 0 deg).
module landmark_pose_2d #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [10:0] tag_id,
  input  wire logic signed [15:0] tag_right,
  input  wire logic signed [15:0] tag_forward,
  input  wire logic signed [15:0] tag_yaw,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic signed [15:0]      robot_x,
  output logic signed [15:0]      robot_y,
  output logic signed [15:0]      bearing,
  output logic                    pose_valid
);
  import lmp_pkg::*;
  localparam int N = (CORDIC_STAGES > TblLen) ? TblLen : CORDIC_STAGES;
  localparam int RW = 34;   // Q4.30 rotation datapath
  localparam int VW = 40;   // vectoring datapath, 17b delta * 2^14 plus growth
  // Stage map: 0 wrap, 1 quadrant, 2..N+1 rotate, N+2 multiply, N+3 sum,
  // N+4 round/sat, N+5 delta, N+6..2N+5 vector, 2N+6 round, 2N+7 clamp, out reg.
  localparam int L = 2 * N + 9;

  // ---------------- configuration registers ----------------
  logic [9:0] known_id;
  logic signed [15:0] landmark_x, landmark_y, landmark_angle;
  always_ff @(posedge clk) begin
    if (rst) begin
      known_id <= '0;
      landmark_x <= 16'sd2048;
      landmark_y <= '0;
      landmark_angle <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KNOWN_ID: known_id <= cfg_data[9:0];
        REG_LM_X: landmark_x <= cfg_data;
        REG_LM_Y: landmark_y <= cfg_data;
        REG_LM_ANGLE: landmark_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid and match travel down a shift line beside the data
  logic [L-2:0] vld, hit;
  logic match;
  assign match = !tag_id[10] && (tag_id[9:0] == known_id);
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[L-3:0], start};
    end
    hit <= {hit[L-3:0], match};
  end

  // delay lines for the offsets, up to the multiply stage
  logic signed [15:0] fwd_d [0:N+1];
  logic signed [15:0] rgt_d [0:N+1];
  always_ff @(posedge clk) begin
    fwd_d[0] <= tag_forward;
    rgt_d[0] <= tag_right;
    for (int k = 1; k <= N + 1; k++) begin
      fwd_d[k] <= fwd_d[k-1];
      rgt_d[k] <= rgt_d[k-1];
    end
  end

  // stage 0: t = angle + 180 - yaw, wrapped to [-180,180) in 1/128 deg
  logic signed [17:0] t_raw;
  logic signed [17:0] t_w;
  assign t_raw = 18'(landmark_angle) + 18'sd23040 - 18'(tag_yaw);
  always_comb begin
    // t_raw spans -42495..88575: at most two corrections
    t_w = t_raw;
    if (t_w >= 18'sd23040) t_w = t_w - 18'sd46080;
    else if (t_w < -18'sd23040) t_w = t_w + 18'sd46080;
    if (t_w >= 18'sd23040) t_w = t_w - 18'sd46080;
    else if (t_w < -18'sd23040) t_w = t_w + 18'sd46080;
  end
  logic signed [17:0] t0;
  always_ff @(posedge clk) t0 <= t_w;

  // stage 1: fold into +-90 deg
  logic signed [AngW-1:0] a_full;
  assign a_full = AngW'(t0) <<< 8;
  logic signed [AngW-1:0] a1;
  logic neg1;
  always_ff @(posedge clk) begin
    if (a_full > Deg90) begin
      a1 <= a_full - Deg180;
      neg1 <= 1'b1;
    end else if (a_full < -Deg90) begin
      a1 <= a_full + Deg180;
      neg1 <= 1'b1;
    end else begin
      a1 <= a_full;
      neg1 <= 1'b0;
    end
  end

  // rotation chain
  logic signed [RW-1:0] rx [0:N];
  logic signed [RW-1:0] ry [0:N];
  logic signed [AngW-1:0] rz [0:N];
  logic [N-1:0] neg_d;
  assign rx[0] = CordicK;
  assign ry[0] = '0;
  assign rz[0] = a1;
  always_ff @(posedge clk) neg_d <= {neg_d[N-2:0], neg1};
  for (genvar g = 0; g < N; g++) begin : g_rot
    lmp_cordic_stage #(.W(RW), .Shift(g), .Vectoring(1'b0)) u_st (
      .clk(clk), .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]),
      .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1]));
  end

  // sign fix and products (stage N+2)
  logic signed [RW-1:0] cs, sn;
  assign cs = neg_d[N-1] ? -rx[N] : rx[N];
  assign sn = neg_d[N-1] ? -ry[N] : ry[N];
  logic signed [50:0] p_fc, p_rs, p_fs, p_rc;
  always_ff @(posedge clk) begin
    p_fc <= 51'(fwd_d[N+1]) * 51'(cs);
    p_rs <= 51'(rgt_d[N+1]) * 51'(sn);
    p_fs <= 51'(fwd_d[N+1]) * 51'(sn);
    p_rc <= 51'(rgt_d[N+1]) * 51'(cs);
  end

  // sums (stage N+3); landmark regs must be held static while items fly (not enforced here)
  logic signed [52:0] px, py;
  always_ff @(posedge clk) begin
    px <= -53'(p_fc) + 53'(p_rs) + (53'(landmark_x) <<< 30) + (53'sd1 <<< 29);
    py <= -53'(p_fs) - 53'(p_rc) + (53'(landmark_y) <<< 30) + (53'sd1 <<< 29);
  end

  // round and saturate (stage N+4)
  logic signed [22:0] px_s, py_s;
  assign px_s = 23'(px >>> 30);
  assign py_s = 23'(py >>> 30);
  function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
    if (v > 23'sd32767) return 16'sh7fff;
    else if (v < -23'sd32768) return -16'sh8000;
    else return 16'(v);
  endfunction
  logic signed [15:0] pos_x, pos_y;
  always_ff @(posedge clk) begin
    pos_x <= sat16(px_s);
    pos_y <= sat16(py_s);
  end

  // delta and half-plane set up (stage N+5)
  logic signed [16:0] dx, dy;
  assign dx = 17'(landmark_x) - 17'(pos_x);
  assign dy = 17'(landmark_y) - 17'(pos_y);
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [AngW-1:0] vz [0:N];
  logic signed [VW-1:0] vx0, vy0;
  logic signed [AngW-1:0] vz0;
  logic [N:0] zero_d;
  always_ff @(posedge clk) begin
    if (dx < 0) begin
      vx0 <= -(VW'(dx) <<< 14);
      vy0 <= -(VW'(dy) <<< 14);
      vz0 <= (dy >= 0) ? Deg180 : -Deg180;
    end else begin
      vx0 <= VW'(dx) <<< 14;
      vy0 <= VW'(dy) <<< 14;
      vz0 <= '0;
    end
  end
  assign vx[0] = vx0;
  assign vy[0] = vy0;
  assign vz[0] = vz0;
  always_ff @(posedge clk) zero_d <= {zero_d[N-1:0], (dx == 0) && (dy == 0)};

  // x/y saved for the output
  logic signed [15:0] ox_d [0:N+2];
  logic signed [15:0] oy_d [0:N+2];
  always_ff @(posedge clk) begin
    ox_d[0] <= pos_x;
    oy_d[0] <= pos_y;
    for (int k = 1; k <= N + 2; k++) begin
      ox_d[k] <= ox_d[k-1];
      oy_d[k] <= oy_d[k-1];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_vec
    lmp_cordic_stage #(.W(VW), .Shift(g), .Vectoring(1'b1)) u_st (
      .clk(clk), .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]),
      .x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1]));
  end

  // round (stage 2N+6) and clamp (stage 2N+7)
  logic signed [17:0] b_r;
  always_ff @(posedge clk) b_r <= zero_d[N] ? '0 : 18'((vz[N] + 26'sd128) >>> 8);
  logic signed [15:0] b_c;
  always_ff @(posedge clk) begin
    if (b_r > 18'sd23040) b_c <= 16'sd23040;
    else if (b_r < -18'sd23040) b_c <= -16'sd23040;
    else b_c <= 16'(b_r);
  end

  // output register
  logic h_o;
  assign h_o = hit[L-2];
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[L-2];
    end
    pose_valid <= h_o;
    robot_x <= h_o ? ox_d[N+2] : '0;
    robot_y <= h_o ? oy_d[N+2] : '0;
    bearing <= h_o ? b_c : '0;
  end
endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lmp_pkg::*;

  localparam int Stages = 16;
  localparam int Latency = 2 * Stages + 9;
  localparam int Settle = Latency + 10;    // quiet cycles before a register write
  localparam int StallLimit = 4000;        // cycles with no traffic before giving up

  // per-stage arctangent, 2^-15 degree
  localparam longint AtanStep [0:15] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57};

  typedef enum logic [1:0] {K_WORD, K_CFG, K_HOLD} pend_kind_e;

  typedef struct {
    pend_kind_e kind;
    logic [15:0] f_id;       // tag_id, or the register index for a write
    logic [15:0] f_right;    // tag_right, or the write data
    logic [15:0] f_fwd;
    logic [15:0] f_yaw;
    bit no_gap;              // driver never idles in front of this word
  } pend_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] brg;
    logic valid;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [10:0] tag_id = '0;
  logic signed [15:0] tag_right = '0;
  logic signed [15:0] tag_forward = '0;
  logic signed [15:0] tag_yaw = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic signed [15:0] robot_x;
  logic signed [15:0] robot_y;
  logic signed [15:0] bearing;
  logic pose_valid;

  landmark_pose_2d #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tag_id(tag_id), .tag_right(tag_right), .tag_forward(tag_forward),
    .tag_yaw(tag_yaw), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .robot_x(robot_x), .robot_y(robot_y),
    .bearing(bearing), .pose_valid(pose_valid));

  always #2 clk = ~clk;

  pend_t pend_q[$];
  pose_t pose_q[$];            // expected poses, oldest first

  // shadow of the block's registers
  logic [9:0] sh_id = 10'd0;
  logic signed [15:0] sh_lx = 16'sd2048;
  logic signed [15:0] sh_ly = 16'sd0;
  logic signed [15:0] sh_ang = 16'sd0;

  int idle_run = 0;            // cycles with nothing expected
  int quiet = 0;               // cycles since the driver last raised start
  int stall_cnt = 0;
  int errors = 0;
  int n_valid = 0, n_invalid = 0, n_cfg = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // CORDIC rotation: a in 2^-15 degree, |a| <= 90 deg; cos/sin in Q2.30
  function automatic void sincos_q30(input longint a, output longint c, output longint s);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    z = a;
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= AtanStep[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += AtanStep[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  // vectoring CORDIC, atan2(dy, dx) in 2^-15 degree
  function automatic longint atan2_deg(input longint dx, input longint dy);
    longint x, y, z, nx;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      // fold to the right half plane, start from +-180
      z = (dy >= 0) ? 5898240 : -5898240;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += AtanStep[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= AtanStep[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic pose_t pose_predict(input logic signed [10:0] id,
                                         input logic signed [15:0] right,
                                         input logic signed [15:0] fwd,
                                         input logic signed [15:0] yaw);
    pose_t r;
    longint t, a, c, s, px, py, rx, ry, b, lx, ly;
    bit flip;
    r = '{x: '0, y: '0, brg: '0, valid: 1'b0};
    if (id < 0 || id[9:0] != sh_id) return r;
    lx = sh_lx;
    ly = sh_ly;
    // heading wraps into [-180, 180)
    t = longint'(sh_ang) + 23040 - longint'(yaw);
    t = ((t % 46080) + 46080) % 46080;
    if (t >= 23040) t -= 46080;
    a = t * 256;
    flip = 0;
    if (a > 2949120) begin
      a -= 5898240;
      flip = 1;
    end else if (a < -2949120) begin
      a += 5898240;
      flip = 1;
    end
    sincos_q30(a, c, s);
    if (flip) begin
      c = -c;
      s = -s;
    end
    px = -longint'(fwd) * c + longint'(right) * s + lx * (64'sd1 <<< 30);
    py = -longint'(fwd) * s - longint'(right) * c + ly * (64'sd1 <<< 30);
    rx = clamp((px + (64'sd1 <<< 29)) >>> 30, -32768, 32767);
    ry = clamp((py + (64'sd1 <<< 29)) >>> 30, -32768, 32767);
    b = clamp((atan2_deg(lx - rx, ly - ry) + 128) >>> 8, -23040, 23040);
    r.x = rx[15:0];
    r.y = ry[15:0];
    r.brg = b[15:0];
    r.valid = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word per accepted start, register writes only when drained
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pend_t hd;
    logic nx_start, nx_we, moved;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      quiet <= 0;
    end else if (start && busy) begin
      quiet <= 0;                          // word still waiting, hold it
    end else begin
      nx_start = 1'b0;
      nx_we = 1'b0;
      if (pend_q.size() > 0) begin
        hd = pend_q[0];
        moved = 1'b0;
        case (hd.kind)
          K_WORD: begin
            if (hd.no_gap || $urandom_range(99) >= 26) begin
              nx_start = 1'b1;
              tag_id <= hd.f_id[10:0];
              tag_right <= hd.f_right;
              tag_forward <= hd.f_fwd;
              tag_yaw <= hd.f_yaw;
              moved = 1'b1;
            end
          end
          K_CFG: begin
            if (quiet >= 2 && idle_run >= Settle) begin
              nx_we = 1'b1;
              cfg_index <= hd.f_id[1:0];
              cfg_data <= hd.f_right;
              moved = 1'b1;
            end
          end
          default: begin
            // sender holds until every pose is back
            if (quiet >= 2 && idle_run >= 1) moved = 1'b1;
          end
        endcase
        if (moved) void'(pend_q.pop_front());
      end
      start <= nx_start;
      cfg_we <= nx_we;
      quiet <= nx_start ? 0 : quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pose_t e;
    logic traffic;
    if (rst) begin
      idle_run <= 0;
      stall_cnt <= 0;
    end else begin
      traffic = 1'b0;
      if (cfg_we) begin
        n_cfg++;
        case (cfg_index)
          REG_KNOWN_ID: sh_id = cfg_data[9:0];
          REG_LM_X: sh_lx = cfg_data;
          REG_LM_Y: sh_ly = cfg_data;
          REG_LM_ANGLE: sh_ang = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        pose_q.push_back(pose_predict(tag_id, tag_right, tag_forward, tag_yaw));
        traffic = 1'b1;
      end
      if (done) begin
        traffic = 1'b1;
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word x=%0d y=%0d bearing=%0d valid=%0b",
                   $time, robot_x, robot_y, bearing, pose_valid);
        end else begin
          e = pose_q.pop_front();
          if (pose_valid) n_valid++; else n_invalid++;
          if (robot_x !== e.x) begin
            errors++;
            $display("%0t: robot_x expected %0d got %0d", $time, e.x, robot_x);
          end
          if (robot_y !== e.y) begin
            errors++;
            $display("%0t: robot_y expected %0d got %0d", $time, e.y, robot_y);
          end
          if (bearing !== e.brg) begin
            errors++;
            $display("%0t: bearing expected %0d got %0d", $time, e.brg, bearing);
          end
          if (pose_valid !== e.valid) begin
            errors++;
            $display("%0t: pose_valid expected %0b got %0b", $time, e.valid, pose_valid);
          end
        end
      end
      idle_run <= (pose_q.size() == 0) ? idle_run + 1 : 0;
      stall_cnt <= traffic ? 0 : stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: timeout, %0d words outstanding", $time, pose_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int cur_id;                  // known_id as the queue will have it

  function automatic void add_word(input int id, input int right, input int fwd,
                                   input int yaw, input bit ng = 0);
    pend_t p;
    p.kind = K_WORD;
    p.f_id = 16'(id);
    p.f_right = 16'(right);
    p.f_fwd = 16'(fwd);
    p.f_yaw = 16'(yaw);
    p.no_gap = ng;
    pend_q.push_back(p);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input int val);
    pend_t p;
    p = '{kind: K_CFG, f_id: 16'(idx), f_right: 16'(val), f_fwd: '0, f_yaw: '0,
          no_gap: 1'b0};
    pend_q.push_back(p);
    if (idx == REG_KNOWN_ID) cur_id = val & 'h3ff;
  endfunction

  function automatic void add_hold();
    pend_t p;
    p = '{kind: K_HOLD, f_id: '0, f_right: '0, f_fwd: '0, f_yaw: '0, no_gap: 1'b0};
    pend_q.push_back(p);
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(3))
      0: return $urandom_range(65535);                   // full range, saturates often
      1: return $urandom_range(8191) - 4096;
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return $urandom_range(2047) - 1024;
    endcase
  endfunction

  function automatic int rand_yaw();
    if ($urandom_range(9) == 0) return $urandom_range(65535);  // beyond +-180, wraps
    return $urandom_range(46080) - 23040;
  endfunction

  function automatic void add_random(input int n, input bit ng);
    int id;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: id = -1;                                  // no detection
        1, 2: id = $urandom_range(2047);             // any id, mostly unknown
        default: id = cur_id;
      endcase
      add_word(id, rand_offset(), rand_offset(), rand_yaw(), ng);
    end
  endfunction

  initial begin
    cur_id = 0;
    // directed, reset registers: landmark at (2.0, 0), angle 0, id 0
    add_word(0, 0, 0, 0);                  // robot on the landmark: zero vector
    add_word(0, 0, 1024, 0);
    add_word(0, 1024, 0, 0);
    add_word(0, 0, 1024, 23040);           // yaw at +180
    add_word(0, 0, 1024, -23040);          // yaw at -180
    add_word(0, 512, 1024, 11520);         // +90
    add_word(0, 512, 1024, -11520);        // -90
    add_word(0, 700, 300, 11521);          // yaw just past +90, heading just under +90, no fold
    add_word(0, 700, 300, -11521);
    add_word(0, 300, 700, 32767);          // yaw beyond range, wraps
    add_word(0, 300, 700, -32768);
    add_word(0, 32767, 32767, 5760);       // large offsets, saturating x
    add_word(0, -32768, -32768, -5760);
    add_word(0, -32768, 32767, 17000);
    add_word(0, 32767, -32768, 0);
    add_word(0, 0, -1024, 23040);          // robot dead ahead of landmark in +x: half turn
    add_word(0, 1, -2048, 0);
    add_word(-1, 1234, 4321, 100);         // no detection
    add_word(1, 1234, 4321, 100);          // unknown id
    add_word(1023, -5, 77, -100);
    add_word(-1024, 5, 5, 5);
    add_random(80, 0);

    // settings sweep, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          add_cfg(REG_KNOWN_ID, 1023);
          add_cfg(REG_LM_X, 32767);
          add_cfg(REG_LM_Y, -32768);
          add_cfg(REG_LM_ANGLE, 23040);
        end
        1: begin
          add_cfg(REG_KNOWN_ID, 0);
          add_cfg(REG_LM_X, -32768);
          add_cfg(REG_LM_Y, 32767);
          add_cfg(REG_LM_ANGLE, -23040);
        end
        2: begin
          add_cfg(REG_KNOWN_ID, 'h2aa);
          add_cfg(REG_LM_X, 0);
          add_cfg(REG_LM_Y, 0);
          add_cfg(REG_LM_ANGLE, 32767);    // outside stated range, wraps
        end
        3: begin
          add_cfg(REG_KNOWN_ID, 'h155);
          add_cfg(REG_LM_ANGLE, -32768);
        end
        default: begin
          add_cfg(REG_KNOWN_ID, $urandom_range(1023));
          add_cfg(REG_LM_X, $urandom_range(65535));
          add_cfg(REG_LM_Y, $urandom_range(65535));
          add_cfg(REG_LM_ANGLE, $urandom_range(46080) - 23040);
        end
      endcase
      add_random(90, ph == 3);            // phase 3 runs back to back
      add_hold();
      add_random(100, 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (pend_q.size() == 0);
    @(negedge clk);
    while (pose_q.size() != 0 || start) @(negedge clk);
    repeat (Latency + 20) @(negedge clk);

    $display("Covered %0d valid and %0d rejected detections over %0d register writes.",
             n_valid, n_invalid, n_cfg);
    $display("Left over: %0d, mismatches: %0d", pose_q.size(), errors);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
